### hw/rtl/depth_pixel_to_registered_point_top_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef DEPTH_PIXEL_TO_REGISTERED_POINT_TOP_DEFINES_SVH
`define DEPTH_PIXEL_TO_REGISTERED_POINT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPRP_ASSERT_IMP(label, clk, rstn, a, b) \
	label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
		else $error("dprp: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DPRP_ASSERT_NXT(label, clk, rstn, a, b) \
	label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
		else $error("dprp: assertion failed");

`endif

### hw/rtl/dprp_pkg.sv
`default_nettype none
package dprp_pkg;
	localparam int COLOR_HEIGHT_DEF = 480;
	localparam int COLOR_WIDTH_DEF  = 640;
	localparam int MAX_DEPTH_MM     = 3000;
	localparam int REG_W            = 16;
	localparam int NUM_W            = 32;  // dividend magnitude
	localparam int DEN_W            = 20;  // divisor width (fits 16 * focal)
	localparam int IDX_W            = 8;

	typedef enum logic [IDX_W-1:0] {
		REG_DEPTH_CX = 8'd0,
		REG_DEPTH_CY = 8'd1,
		REG_DEPTH_FX = 8'd2,
		REG_DEPTH_FY = 8'd3,
		REG_COLOR_CX = 8'd4,
		REG_COLOR_CY = 8'd5,
		REG_COLOR_FX = 8'd6,
		REG_COLOR_FY = 8'd7
	} reg_idx_t;
endpackage
`default_nettype wire

### hw/rtl/depth_pixel_to_registered_point_top.sv
// Depth pixel to registered 3-D point.
// Input channel: pixel_row, pixel_col, depth_mm with pix_valid / pix_stall.
// Output channel: point_x/y/z, color_row, color_col with pt_valid / pt_stall.
// A word moves at a clock edge where valid is high and stall is low.
// Pixels with zero depth, depth above 3000 mm, or a color pixel outside the
// color frame produce no output word.
// The pipeline has three arithmetic stages, 32 divider stages (one
// quotient bit per stage, four dividers in parallel), one output register.
// Throughput is one pixel per cycle while the output does not stall.
// A stall on the output freezes the whole pipeline while a word waits;
// pix_stall is raised in that case and nothing is lost or repeated.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
// one of eight 16-bit intrinsics registers; write only while idle.
// Reset clears all valid bits and loads the default intrinsics.
`default_nettype none
`include "depth_pixel_to_registered_point_top_defines.svh"
module depth_pixel_to_registered_point_top #(
	parameter int COLOR_HEIGHT = dprp_pkg::COLOR_HEIGHT_DEF,
	parameter int COLOR_WIDTH  = dprp_pkg::COLOR_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [dprp_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [dprp_pkg::REG_W-1:0] cfg_data,
	input  wire logic                       pix_valid,
	output logic                            pix_stall,
	input  wire logic [9:0]                 pixel_row,
	input  wire logic [9:0]                 pixel_col,
	input  wire logic [15:0]                depth_mm,
	output logic                            pt_valid,
	input  wire logic                       pt_stall,
	output logic signed [31:0]              point_x,
	output logic signed [31:0]              point_y,
	output logic [11:0]                     point_z,
	output logic [8:0]                      color_row,
	output logic [9:0]                      color_col
);
	import dprp_pkg::*;

	localparam int LAT = NUM_W;

	// intrinsics registers
	logic [REG_W-1:0] dcx_q, dcy_q, dfx_q, dfy_q, ccx_q, ccy_q, cfx_q, cfy_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcx_q <= 16'd5120; dcy_q <= 16'd3840; dfx_q <= 16'd9600; dfy_q <= 16'd9600;
			ccx_q <= 16'd5120; ccy_q <= 16'd3840; cfx_q <= 16'd9600; cfy_q <= 16'd9600;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEPTH_CX: dcx_q <= cfg_data;
				REG_DEPTH_CY: dcy_q <= cfg_data;
				REG_DEPTH_FX: dfx_q <= cfg_data;
				REG_DEPTH_FY: dfy_q <= cfg_data;
				REG_COLOR_CX: ccx_q <= cfg_data;
				REG_COLOR_CY: ccy_q <= cfg_data;
				REG_COLOR_FX: cfx_q <= cfg_data;
				REG_COLOR_FY: cfy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a zero depth focal length counts as one
	logic [REG_W-1:0] fxn, fyn;
	assign fxn = (dfx_q == '0) ? REG_W'(1) : dfx_q;
	assign fyn = (dfy_q == '0) ? REG_W'(1) : dfy_q;

	// pipeline advances unless a finished word is held
	logic en;
	assign en        = !(pt_valid && pt_stall);
	assign pix_stall = !en;

	// stage 1: offsets and depth gate
	logic               vld_s1, keep_s1;
	logic signed [16:0] offx_s1, offy_s1;
	logic [11:0]        d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_s1 <= (depth_mm != '0) && (depth_mm <= 16'(MAX_DEPTH_MM));
			offx_s1 <= $signed({1'b0, pixel_col, 4'b0}) - $signed({1'b0, dcx_q});
			offy_s1 <= $signed({1'b0, pixel_row, 4'b0}) - $signed({1'b0, dcy_q});
			d_s1    <= depth_mm[11:0];
		end
	end

	// stage 2: products
	logic               vld_s2, keep_s2;
	logic [11:0]        d_s2;
	logic signed [29:0] pdx_s2, pdy_s2;
	logic signed [33:0] pcx_s2, pcy_s2;
	logic [31:0]        kcx_s2, kcy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_s2 <= keep_s1;
			d_s2    <= d_s1;
			pdx_s2  <= 30'(offx_s1 * $signed({1'b0, d_s1}));
			pdy_s2  <= 30'(offy_s1 * $signed({1'b0, d_s1}));
			pcx_s2  <= 34'(offx_s1 * $signed({1'b0, cfx_q}));
			pcy_s2  <= 34'(offy_s1 * $signed({1'b0, cfy_q}));
			kcx_s2  <= ccx_q * fxn;
			kcy_s2  <= ccy_q * fyn;
		end
	end

	// stage 3: numerators as sign and magnitude
	logic signed [33:0] ncx, ncy;
	logic [29:0]        apx, apy;
	logic [33:0]        acx, acy;
	always_comb begin
		ncx = pcx_s2 + $signed({2'b0, kcx_s2});
		ncy = pcy_s2 + $signed({2'b0, kcy_s2});
		apx = pdx_s2[29] ? 30'(-pdx_s2) : 30'(pdx_s2);
		apy = pdy_s2[29] ? 30'(-pdy_s2) : 30'(pdy_s2);
		acx = ncx[33] ? 34'(-ncx) : 34'(ncx);
		acy = ncy[33] ? 34'(-ncy) : 34'(ncy);
	end

	logic              vld_s3, keep_s3;
	logic [11:0]       d_s3;
	logic [3:0]        sgn_s3;  // {px, py, ccol, crow}
	logic [NUM_W-1:0]  npx_s3, npy_s3, ncx_s3, ncy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	// a color numerator past 32 bits always lands beyond the frame, so clamp it
	always_ff @(posedge clk) begin
		if (en) begin
			keep_s3 <= keep_s2;
			d_s3    <= d_s2;
			sgn_s3  <= {pdx_s2[29], pdy_s2[29], ncx[33], ncy[33]};
			npx_s3  <= NUM_W'({apx, 4'b0});
			npy_s3  <= NUM_W'({apy, 4'b0});
			ncx_s3  <= (acx[33:32] != 2'b00) ? '1 : acx[NUM_W-1:0];
			ncy_s3  <= (acy[33:32] != 2'b00) ? '1 : acy[NUM_W-1:0];
		end
	end

	// dividers
	logic [NUM_W-1:0] qpx, qpy, qcx, qcy;

	dprp_div #(.NW(NUM_W), .DW(DEN_W)) u_div_px (
		.clk(clk), .en(en), .num(npx_s3), .den(DEN_W'(fxn)), .quot(qpx));
	dprp_div #(.NW(NUM_W), .DW(DEN_W)) u_div_py (
		.clk(clk), .en(en), .num(npy_s3), .den(DEN_W'(fyn)), .quot(qpy));
	dprp_div #(.NW(NUM_W), .DW(DEN_W)) u_div_cx (
		.clk(clk), .en(en), .num(ncx_s3), .den({fxn, 4'b0}), .quot(qcx));
	dprp_div #(.NW(NUM_W), .DW(DEN_W)) u_div_cy (
		.clk(clk), .en(en), .num(ncy_s3), .den({fyn, 4'b0}), .quot(qcy));

	// side payload delay line matching the divider latency
	logic        vld_sd  [LAT];
	logic        keep_sd [LAT];
	logic [11:0] d_sd    [LAT];
	logic [3:0]  sgn_sd  [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_sd[i] <= 1'b0;
		end else if (en) begin
			vld_sd[0] <= vld_s3;
			for (int i = 1; i < LAT; i++) vld_sd[i] <= vld_sd[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_sd[0] <= keep_s3;
			d_sd[0]    <= d_s3;
			sgn_sd[0]  <= sgn_s3;
			for (int i = 1; i < LAT; i++) begin
				keep_sd[i] <= keep_sd[i-1];
				d_sd[i]    <= d_sd[i-1];
				sgn_sd[i]  <= sgn_sd[i-1];
			end
		end
	end

	// final: sign, saturation, frame check
	logic [3:0]        sgn_f;
	logic signed [31:0] px_f, py_f;
	logic               ok_f;
	always_comb begin
		sgn_f = sgn_sd[LAT-1];
		if (sgn_f[3]) begin
			px_f = (qpx > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-qpx);
		end else begin
			px_f = (qpx > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qpx);
		end
		if (sgn_f[2]) begin
			py_f = (qpy > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-qpy);
		end else begin
			py_f = (qpy > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qpy);
		end
		ok_f = !(sgn_f[1] && (qcx != '0)) && (qcx < 32'(COLOR_WIDTH))
			&& !(sgn_f[0] && (qcy != '0)) && (qcy < 32'(COLOR_HEIGHT));
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
		end else if (en) begin
			pt_valid <= vld_sd[LAT-1] && keep_sd[LAT-1] && ok_f;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			point_x   <= px_f;
			point_y   <= py_f;
			point_z   <= d_sd[LAT-1];
			color_row <= qcy[8:0];
			color_col <= qcx[9:0];
		end
	end

	`DPRP_ASSERT_IMP(a_z_range, clk, arst_n, pt_valid,
		(point_z != '0) && (point_z <= 12'(MAX_DEPTH_MM)))
	`DPRP_ASSERT_IMP(a_in_frame, clk, arst_n, pt_valid,
		(32'(color_col) < 32'(COLOR_WIDTH)) && (32'(color_row) < 32'(COLOR_HEIGHT)))
	`DPRP_ASSERT_IMP(a_stall_src, clk, arst_n, pix_stall, pt_valid && pt_stall)
endmodule
`default_nettype wire

### hw/rtl/dprp_div.sv
`default_nettype none
// Pipelined unsigned restoring divider, one quotient bit per stage.
module dprp_div #(
	parameter int NW = 32,
	parameter int DW = 20
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quot
);
	logic [NW-1:0] num_s [NW+1];
	logic [NW-1:0] quo_s [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [DW-1:0] den_s [NW+1];

	// stage 0 is the incoming word
	always_comb begin
		num_s[0] = num;
		quo_s[0] = '0;
		rem_s[0] = '0;
		den_s[0] = den;
	end

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        fits;
		assign trial = {rem_s[k], num_s[k][NW-1]};
		assign fits  = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= {num_s[k][NW-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][NW-2:0], fits};
				den_s[k+1] <= den_s[k];
				if (fits) begin
					rem_s[k+1] <= DW'(trial - {1'b0, den_s[k]});
				end else begin
					rem_s[k+1] <= trial[DW-1:0];
				end
			end
		end
	end

	assign quot = quo_s[NW];
endmodule
`default_nettype wire
